// ===== sv/sck_pkg.sv =====
// Shared types, constants and arithmetic helpers of the SPH cubic spline kernel evaluator.
// Used by every module of the block; depends on nothing.
package sck_pkg;

  localparam int unsigned FRAC_BITS_DEF   = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam int unsigned EXTENT_W        = 31;
  localparam int unsigned WEIGHT_W        = 30;
  localparam int unsigned ROOT_STEPS      = 32;
  localparam int unsigned QUOT_W          = 32;

  // 1/pi in Q2.30.
  localparam logic [28:0] INV_PI = 29'd341782638;
  // Largest weight the kernel can produce, W(0) = 1/pi.
  localparam logic [WEIGHT_W-1:0] WEIGHT_PEAK = 30'd341782638;

  typedef struct packed {
    logic signed [31:0] sep_x;
    logic signed [31:0] sep_y;
    logic signed [31:0] sep_z;
    logic signed [31:0] h_xx;
    logic signed [31:0] h_xy;
    logic signed [31:0] h_xz;
    logic signed [31:0] h_yy;
    logic signed [31:0] h_yz;
    logic signed [31:0] h_zz;
  } sck_in_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic signed [31:0]  grad_x;
    logic signed [31:0]  grad_y;
    logic signed [31:0]  grad_z;
    logic                in_support;
  } sck_out_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [31:0] xx;
    logic signed [31:0] xy;
    logic signed [31:0] xz;
    logic signed [31:0] yy;
    logic signed [31:0] yz;
    logic signed [31:0] zz;
  } tensor_t;

  // A classified item as it sits in the queue between front and back.
  typedef struct packed {
    vec_t        eta;
    tensor_t     h;
    logic [63:0] dist2;
    logic        support;
    logic        in_reach;
    logic        inner;
  } sck_item_t;

  // Divide by 2^n, rounding to nearest with halves away from zero.
  function automatic logic signed [67:0] rnd_q(input logic signed [67:0] v,
                                               input int unsigned n);
    logic signed [67:0] half;
    logic signed [67:0] mag;
    half = 68'sd1 <<< (n - 1);
    mag  = -v;
    if (v >= 0) begin
      rnd_q = (v + half) >>> n;
    end else begin
      rnd_q = -((mag + half) >>> n);
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v > 68'sd2147483647) begin
      sat32 = 32'sh7fffffff;
    end else if (v < -68'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

// ===== sv/sph_cubic_spline_kernel_eval.sv =====
// Top level of the SPH cubic spline kernel evaluator: extent register, front end,
// item queue and back end. Depends on sck_pkg, sck_front, sck_queue and sck_back.
//
// The block takes one item per clock unless in_stall_o is high: a separation vector x
// and a symmetric smoothing tensor H, all signed Q16.16 (FRAC_BITS fraction bits).
// For each item it returns one result: the cubic B-spline weight W in unsigned Q0.30,
// the gradient H.(eta * dW / |eta|) in saturated signed Q16.16, and an in-support
// flag, where eta = H.x. Items outside the extent give all zeros; items inside the
// extent but beyond a scaled distance of two give a zero weight and gradient. The
// sustained rate is one item per cycle while the output is not stalled. An item
// passes through the front end, the queue and the back end, whose bulk is the
// pipelined square root and the pipelined gradient divider, each producing one
// result bit per stage. A stalled output holds the whole back end; the four-entry
// queue lets the front end keep accepting until it fills, at which point in_stall_o
// rises. The extent register is written through the configuration channel, which is
// always ready; its square, which the front end compares against, is registered from
// it in the cycle after a write, so a write should only be made while the block is
// idle.
module sph_cubic_spline_kernel_eval #(
  parameter int unsigned FRAC_BITS   = sck_pkg::FRAC_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = sck_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  sck_pkg::sck_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output sck_pkg::sck_out_t              out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sck_pkg::EXTENT_W-1:0]   cfg_data_i
);

  localparam logic [sck_pkg::EXTENT_W-1:0] EXTENT_RESET =
    sck_pkg::EXTENT_W'(2) << FRAC_BITS;
  localparam logic [61:0] EXT2_RESET = 62'(EXTENT_RESET) * 62'(EXTENT_RESET);

  logic [sck_pkg::EXTENT_W-1:0] extent_q;
  logic [61:0]                  ext2_q;

  logic               front_en;
  logic               front_valid;
  sck_pkg::sck_item_t front_item;
  logic               q_full, q_empty, q_pop;
  sck_pkg::sck_item_t q_head;

  // The extent is squared once so that the front end compares squared lengths.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      extent_q <= EXTENT_RESET;
      ext2_q   <= EXT2_RESET;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        extent_q <= cfg_data_i;
      end
      ext2_q <= 62'(extent_q) * 62'(extent_q);
    end
  end

  // The front end advances whenever the queue has room for what it hands over.
  assign front_en   = !q_full;
  assign in_stall_o = q_full;

  sck_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (front_en),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .ext2_i     (ext2_q),
    .valid_o    (front_valid),
    .item_o     (front_item)
  );

  sck_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_en && front_valid),
    .item_i  (front_item),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  sck_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== sv/sck_front.sv =====
// Front end: accepts items, forms eta = H.x and its squared length, and classifies
// the item against the support radius and the spline regions. Depends on sck_pkg.
module sck_front #(
  parameter int unsigned FRAC_BITS = sck_pkg::FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                in_valid_i,
  input  sck_pkg::sck_in_t    in_data_i,
  input  logic [61:0]         ext2_i,
  output logic                valid_o,
  output sck_pkg::sck_item_t  item_o
);

  localparam logic [63:0] REACH_SQ = 64'd4 << (2 * FRAC_BITS);
  localparam logic [63:0] INNER_SQ = 64'd1 << (2 * FRAC_BITS);

  logic                s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic signed [63:0]  s1_p_q [9];
  logic signed [63:0]  s1_p_d [9];
  sck_pkg::tensor_t    s1_h_q, s2_h_q, s3_h_q;
  sck_pkg::vec_t       s2_eta_q, s3_eta_q;
  sck_pkg::vec_t       s2_eta_d;
  logic                s2_huge_q, s3_huge_q;
  logic                s2_huge_d;
  logic [63:0]         s3_sq_q [3];
  logic [63:0]         s3_sq_d [3];
  sck_pkg::sck_item_t  s4_item_q, s4_item_d;

  // Stage 1: the nine products of the tensor rows with x.
  always_comb begin
    s1_p_d[0] = in_data_i.h_xx * in_data_i.sep_x;
    s1_p_d[1] = in_data_i.h_xy * in_data_i.sep_y;
    s1_p_d[2] = in_data_i.h_xz * in_data_i.sep_z;
    s1_p_d[3] = in_data_i.h_xy * in_data_i.sep_x;
    s1_p_d[4] = in_data_i.h_yy * in_data_i.sep_y;
    s1_p_d[5] = in_data_i.h_yz * in_data_i.sep_z;
    s1_p_d[6] = in_data_i.h_xz * in_data_i.sep_x;
    s1_p_d[7] = in_data_i.h_yz * in_data_i.sep_y;
    s1_p_d[8] = in_data_i.h_zz * in_data_i.sep_z;
  end

  // Stage 2: rounded row sums; anything at or beyond 2^31 is out of support.
  always_comb begin
    logic signed [67:0] e_full [3];
    for (int i = 0; i < 3; i++) begin
      e_full[i] = sck_pkg::rnd_q(68'(s1_p_q[3*i]), FRAC_BITS)
                + sck_pkg::rnd_q(68'(s1_p_q[3*i+1]), FRAC_BITS)
                + sck_pkg::rnd_q(68'(s1_p_q[3*i+2]), FRAC_BITS);
    end
    s2_huge_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (e_full[i] >= 68'sd2147483648 || e_full[i] <= -68'sd2147483648) begin
        s2_huge_d = 1'b1;
      end
    end
    s2_eta_d.x = e_full[0][31:0];
    s2_eta_d.y = e_full[1][31:0];
    s2_eta_d.z = e_full[2][31:0];
  end

  // Stage 3: squares of the eta components.
  always_comb begin
    s3_sq_d[0] = 64'(s2_eta_q.x * s2_eta_q.x);
    s3_sq_d[1] = 64'(s2_eta_q.y * s2_eta_q.y);
    s3_sq_d[2] = 64'(s2_eta_q.z * s2_eta_q.z);
  end

  // Stage 4: squared length and classification.
  always_comb begin
    s4_item_d.eta      = s3_eta_q;
    s4_item_d.h        = s3_h_q;
    s4_item_d.dist2    = s3_sq_q[0] + s3_sq_q[1] + s3_sq_q[2];
    s4_item_d.support  = !s3_huge_q && (s4_item_d.dist2 <= {2'b00, ext2_i});
    s4_item_d.in_reach = s4_item_d.dist2 <= REACH_SQ;
    s4_item_d.inner    = s4_item_d.dist2 <= INNER_SQ;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else if (en_i) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_p_q    <= s1_p_d;
      s1_h_q    <= '{xx: in_data_i.h_xx, xy: in_data_i.h_xy, xz: in_data_i.h_xz,
                     yy: in_data_i.h_yy, yz: in_data_i.h_yz, zz: in_data_i.h_zz};
      s2_eta_q  <= s2_eta_d;
      s2_huge_q <= s2_huge_d;
      s2_h_q    <= s1_h_q;
      s3_sq_q   <= s3_sq_d;
      s3_eta_q  <= s2_eta_q;
      s3_huge_q <= s2_huge_q;
      s3_h_q    <= s2_h_q;
      s4_item_q <= s4_item_d;
    end
  end

  assign valid_o = s4_v_q;
  assign item_o  = s4_item_q;

endmodule

// ===== sv/sck_queue.sv =====
// Short FIFO of classified items between the front end and the back end.
// Depends on sck_pkg for the item type.
module sck_queue #(
  parameter int unsigned DEPTH = sck_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sck_pkg::sck_item_t  item_i,
  input  logic                pop_i,
  output logic                full_o,
  output logic                empty_o,
  output sck_pkg::sck_item_t  head_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sck_pkg::sck_item_t mem_q [DEPTH];
  logic [AW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [AW:0]        cnt_q;

  assign full_o  = cnt_q == (AW+1)'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== sv/sck_back.sv =====
// Back end: square root, spline polynomial, gradient division and the final tensor
// product, as one pipeline that holds as a whole when the output is stalled. Uses sck_pkg.
module sck_back #(
  parameter int unsigned FRAC_BITS = sck_pkg::FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  sck_pkg::sck_item_t  head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sck_pkg::sck_out_t   out_data_o
);

  localparam int unsigned ROOT_SHIFT = 60 - 2 * FRAC_BITS;
  localparam int unsigned ETA_SHIFT  = 30 - FRAC_BITS;
  localparam int unsigned STEPS      = sck_pkg::ROOT_STEPS;
  localparam int unsigned QW         = sck_pkg::QUOT_W;

  typedef struct packed {
    logic             support;
    logic             in_reach;
    logic             inner;
    sck_pkg::vec_t    eta;
    sck_pkg::tensor_t h;
  } carry_t;

  typedef struct packed {
    logic                         support;
    logic                         grad_ok;
    logic [sck_pkg::WEIGHT_W-1:0] weight;
    sck_pkg::tensor_t             h;
    logic [31:0]                  divisor;
    logic [2:0]                   neg;
  } div_carry_t;

  logic en;
  logic out_valid_q;
  sck_pkg::sck_out_t out_data_q, out_data_d;

  assign en    = !out_valid_q || !out_stall_i;
  assign pop_o = en && !empty_i;

  // ---------------- square root, one result bit per stage ----------------
  logic [STEPS:0] rt_v_q;
  logic [63:0]    rt_rem_q  [0:STEPS];
  logic [63:0]    rt_root_q [0:STEPS];
  carry_t         rt_c_q    [0:STEPS];
  logic [63:0]    rt_rem_d  [1:STEPS];
  logic [63:0]    rt_root_d [1:STEPS];
  logic [63:0]    rad_d;
  carry_t         head_c;

  always_comb begin
    head_c.support  = head_i.support;
    head_c.in_reach = head_i.in_reach;
    head_c.inner    = head_i.inner;
    head_c.eta      = head_i.eta;
    head_c.h        = head_i.h;
    rad_d = head_i.in_reach ? {1'b0, 63'(head_i.dist2 << ROOT_SHIFT)} : '0;
  end

  always_comb begin
    logic [63:0] step_w;
    logic [63:0] trial;
    for (int k = 0; k < STEPS; k++) begin
      step_w = 64'd1 << (62 - 2 * k);
      trial  = rt_root_q[k] + step_w;
      if (rt_rem_q[k] >= trial) begin
        rt_rem_d[k+1]  = rt_rem_q[k] - trial;
        rt_root_d[k+1] = (rt_root_q[k] >> 1) + step_w;
      end else begin
        rt_rem_d[k+1]  = rt_rem_q[k];
        rt_root_d[k+1] = rt_root_q[k] >> 1;
      end
    end
  end

  // ---------------- polynomial stages ----------------
  logic        p1_v_q, p2_v_q, p3_v_q, p4_v_q;
  carry_t      p1_c_q, p2_c_q, p3_c_q, p4_c_q;
  logic [31:0] p1_u_q, p2_u_q, p3_u_q, p4_u_q;
  logic [30:0] p1_a_q;
  logic [61:0] p1_prod_q, p2_prod_q;
  logic [30:0] p2_sq_q;
  logic signed [65:0] p3_wprod_q, p3_dprod_q;
  logic [sck_pkg::WEIGHT_W-1:0] p4_weight_q;
  logic signed [31:0]           p4_dw_q;

  logic [31:0]        u_w;
  logic [31:0]        t_w;
  logic [30:0]        a_d;
  logic [30:0]        sq_d, cube_d;
  logic signed [65:0] wprod_d, dprod_d;
  logic [sck_pkg::WEIGHT_W-1:0] weight_d;
  logic signed [31:0]           dw_d;

  always_comb begin
    u_w = rt_root_q[STEPS][31:0];
    t_w = 32'h8000_0000 - u_w;
    a_d = rt_c_q[STEPS].inner ? u_w[30:0] : t_w[30:0];
  end

  assign sq_d = 31'(sck_pkg::rnd_q(68'(p1_prod_q), 30));

  always_comb begin
    logic signed [35:0] sq_s, cube_s, n_v, d_v;
    logic signed [65:0] n_w, d_w, inv_w;
    cube_d = 31'(sck_pkg::rnd_q(68'(p2_prod_q), 30));
    sq_s   = 36'(p2_sq_q);
    cube_s = 36'(cube_d);
    if (p2_c_q.inner) begin
      n_v = (36'sd4 <<< 30) - 36'sd6 * sq_s + 36'sd3 * cube_s;
      if (n_v < 0) begin
        n_v = '0;
      end
      d_v = 36'sd9 * sq_s - (36'sd6 <<< 30);
    end else begin
      n_v = cube_s;
      d_v = -(36'sd3 * sq_s);
    end
    n_w     = n_v;
    d_w     = d_v;
    inv_w   = 66'(sck_pkg::INV_PI);
    wprod_d = n_w * inv_w;
    dprod_d = d_w * inv_w;
  end

  always_comb begin
    logic signed [67:0] wt;
    wt = sck_pkg::rnd_q(68'(p3_wprod_q), 32);
    if (wt < 0) begin
      wt = '0;
    end
    if (wt > 68'sd1073741823) begin
      wt = 68'sd1073741823;
    end
    weight_d = (p3_c_q.support && p3_c_q.in_reach) ? wt[sck_pkg::WEIGHT_W-1:0] : '0;
    dw_d     = 32'(sck_pkg::rnd_q(68'(p3_dprod_q), 32));
  end

  // ---------------- gradient division, one quotient bit per stage ----------------
  logic [QW:0]          dv_v_q;
  logic [2:0][62:0]     dv_rem_q [0:QW];
  logic [2:0][QW-1:0]   dv_quo_q [0:QW];
  div_carry_t           dv_c_q   [0:QW];
  logic [2:0][62:0]     dv_rem_d [1:QW];
  logic [2:0][QW-1:0]   dv_quo_d [1:QW];
  logic [2:0][62:0]     num_d;
  div_carry_t           dv_c_d;

  always_comb begin
    logic signed [31:0] e [3];
    logic [31:0]        mag_e;
    logic [31:0]        scaled;
    logic [31:0]        mag_dw;
    e[0] = p4_c_q.eta.x;
    e[1] = p4_c_q.eta.y;
    e[2] = p4_c_q.eta.z;
    mag_dw = p4_dw_q[31] ? 32'(-p4_dw_q) : 32'(p4_dw_q);
    for (int i = 0; i < 3; i++) begin
      mag_e     = e[i][31] ? 32'(-e[i]) : 32'(e[i]);
      scaled    = mag_e << ETA_SHIFT;
      num_d[i]  = 63'(scaled) * 63'(mag_dw[30:0]);
      dv_c_d.neg[i] = e[i][31] ^ p4_dw_q[31];
    end
    dv_c_d.support = p4_c_q.support;
    dv_c_d.grad_ok = p4_c_q.support && p4_c_q.in_reach && (p4_u_q != '0);
    dv_c_d.weight  = p4_weight_q;
    dv_c_d.h       = p4_c_q.h;
    dv_c_d.divisor = p4_u_q;
  end

  always_comb begin
    logic [62:0] shifted;
    for (int k = 0; k < QW; k++) begin
      shifted = 63'(dv_c_q[k].divisor) << (QW - 1 - k);
      for (int i = 0; i < 3; i++) begin
        if (dv_rem_q[k][i] >= shifted) begin
          dv_rem_d[k+1][i] = dv_rem_q[k][i] - shifted;
          dv_quo_d[k+1][i] = dv_quo_q[k][i] | (QW'(1) << (QW - 1 - k));
        end else begin
          dv_rem_d[k+1][i] = dv_rem_q[k][i];
          dv_quo_d[k+1][i] = dv_quo_q[k][i];
        end
      end
    end
  end

  // ---------------- tensor times scaled eta ----------------
  logic               g1_v_q;
  logic signed [64:0] g1_p_q [9];
  logic signed [64:0] g1_p_d [9];
  div_carry_t         g1_c_q;

  always_comb begin
    logic signed [32:0] w [3];
    logic signed [31:0] hm [9];
    sck_pkg::tensor_t   h;
    h = dv_c_q[QW].h;
    hm[0] = h.xx; hm[1] = h.xy; hm[2] = h.xz;
    hm[3] = h.xy; hm[4] = h.yy; hm[5] = h.yz;
    hm[6] = h.xz; hm[7] = h.yz; hm[8] = h.zz;
    for (int i = 0; i < 3; i++) begin
      w[i] = dv_c_q[QW].neg[i] ? -$signed({1'b0, dv_quo_q[QW][i]})
                               : $signed({1'b0, dv_quo_q[QW][i]});
    end
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        g1_p_d[3*j+k] = hm[3*j+k] * w[k];
      end
    end
  end

  always_comb begin
    logic signed [67:0] acc [3];
    logic signed [31:0] g   [3];
    for (int j = 0; j < 3; j++) begin
      acc[j] = g1_p_q[3*j] + g1_p_q[3*j+1] + g1_p_q[3*j+2];
      g[j]   = g1_c_q.grad_ok ? sck_pkg::sat32(sck_pkg::rnd_q(acc[j], 30)) : '0;
    end
    out_data_d.weight     = g1_c_q.weight;
    out_data_d.grad_x     = g[0];
    out_data_d.grad_y     = g[1];
    out_data_d.grad_z     = g[2];
    out_data_d.in_support = g1_c_q.support;
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_v_q      <= '0;
      p1_v_q      <= 1'b0;
      p2_v_q      <= 1'b0;
      p3_v_q      <= 1'b0;
      p4_v_q      <= 1'b0;
      dv_v_q      <= '0;
      g1_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      rt_v_q      <= {rt_v_q[STEPS-1:0], !empty_i};
      p1_v_q      <= rt_v_q[STEPS];
      p2_v_q      <= p1_v_q;
      p3_v_q      <= p2_v_q;
      p4_v_q      <= p3_v_q;
      dv_v_q      <= {dv_v_q[QW-1:0], p4_v_q};
      g1_v_q      <= dv_v_q[QW];
      out_valid_q <= g1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rt_rem_q[0]  <= rad_d;
      rt_root_q[0] <= '0;
      rt_c_q[0]    <= head_c;
      for (int k = 1; k <= STEPS; k++) begin
        rt_rem_q[k]  <= rt_rem_d[k];
        rt_root_q[k] <= rt_root_d[k];
        rt_c_q[k]    <= rt_c_q[k-1];
      end
      p1_c_q      <= rt_c_q[STEPS];
      p1_u_q      <= u_w;
      p1_a_q      <= a_d;
      p1_prod_q   <= 62'(a_d) * 62'(a_d);
      p2_c_q      <= p1_c_q;
      p2_u_q      <= p1_u_q;
      p2_sq_q     <= sq_d;
      p2_prod_q   <= 62'(sq_d) * 62'(p1_a_q);
      p3_c_q      <= p2_c_q;
      p3_u_q      <= p2_u_q;
      p3_wprod_q  <= wprod_d;
      p3_dprod_q  <= dprod_d;
      p4_c_q      <= p3_c_q;
      p4_u_q      <= p3_u_q;
      p4_weight_q <= weight_d;
      p4_dw_q     <= dw_d;
      dv_rem_q[0] <= num_d;
      dv_quo_q[0] <= '0;
      dv_c_q[0]   <= dv_c_d;
      for (int k = 1; k <= QW; k++) begin
        dv_rem_q[k] <= dv_rem_d[k];
        dv_quo_q[k] <= dv_quo_d[k];
        dv_c_q[k]   <= dv_c_q[k-1];
      end
      g1_p_q      <= g1_p_d;
      g1_c_q      <= dv_c_q[QW];
      out_data_q  <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== sv/sck_checker.sv =====
// Port-level checks of the kernel evaluator's result channel, bound to the top level.
// Depends on sck_pkg and sph_cubic_spline_kernel_eval.
module sck_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_stall_i,
  input sck_pkg::sck_out_t out_data_i
);

  // A stalled result stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed");

  // Outside the support every field is zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.in_support |->
      out_data_i.weight == '0 && out_data_i.grad_x == '0 &&
      out_data_i.grad_y == '0 && out_data_i.grad_z == '0)
    else $error("nonzero result outside support");

  // The weight never exceeds its value at the center.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.weight <= sck_pkg::WEIGHT_PEAK)
    else $error("weight above kernel peak");

endmodule

bind sph_cubic_spline_kernel_eval sck_checker u_sck_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);

// ===== tb/sv/sph_cubic_spline_kernel_eval_tb.sv =====
// Self-checking testbench for the SPH cubic spline kernel evaluator.
// Depends on sck_pkg and sph_cubic_spline_kernel_eval; needs no files or arguments.
`timescale 1ns / 100ps

module sph_cubic_spline_kernel_eval_tb;

  localparam int unsigned FRAC = 16;
  localparam longint ONE30 = 64'sd1 << 30;
  localparam longint INV_PI_Q30 = 64'sd341782638;
  localparam longint LIM31 = 64'sd1 << 31;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam longint unsigned CYCLE_LIMIT = 400000;
  localparam logic [sck_pkg::EXTENT_W-1:0] EXTENT_RESET = 31'd131072;
  localparam logic [sck_pkg::EXTENT_W-1:0] EXTENT_MAX = 31'h7fffffff;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  sck_pkg::sck_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  sck_pkg::sck_out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [sck_pkg::EXTENT_W-1:0] cfg_data_i = '0;

  // The testbench copy of the extent register, updated when a write is accepted.
  logic [sck_pkg::EXTENT_W-1:0] extent_q = EXTENT_RESET;
  // Kernel results predicted for accepted items, oldest first.
  sck_pkg::sck_out_t kernel_results_q[$];
  int unsigned error_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  longint unsigned cycle_count = 0;

  sph_cubic_spline_kernel_eval i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Divides by 2^n and rounds to nearest, with halves going away from zero.
  function automatic longint round_shift(input longint v, input int unsigned n);
    longint half;
    half = 64'sd1 <<< (n - 1);
    if (v >= 0) begin
      return (v + half) >>> n;
    end
    return -((-v + half) >>> n);
  endfunction

  // Bit-serial integer square root, floor of the exact root.
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned bitpos;
    root = 0;
    bitpos = 64'd1 << 62;
    while (bitpos > v) bitpos >>= 2;
    while (bitpos != 0) begin
      if (v >= root + bitpos) begin
        v -= root + bitpos;
        root = (root >> 1) + bitpos;
      end else begin
        root >>= 1;
      end
      bitpos >>= 2;
    end
    return root;
  endfunction

  // Computes the weight, gradient and support flag of one item at the current extent.
  function automatic sck_pkg::sck_out_t kernel_eval(input sck_pkg::sck_in_t item);
    sck_pkg::sck_out_t res;
    longint sep[3];
    longint h[3][3];
    longint eta[3];
    longint wv[3];
    longint wt;
    longint dw;
    longint acc;
    longint e2, e3, n4, d4, t, t2, t3;
    longint unsigned dist2, ext2, u;
    bit support;
    res = '0;
    sep[0] = longint'(item.sep_x);
    sep[1] = longint'(item.sep_y);
    sep[2] = longint'(item.sep_z);
    h[0][0] = longint'(item.h_xx);
    h[0][1] = longint'(item.h_xy);
    h[1][0] = h[0][1];
    h[0][2] = longint'(item.h_xz);
    h[2][0] = h[0][2];
    h[1][1] = longint'(item.h_yy);
    h[1][2] = longint'(item.h_yz);
    h[2][1] = h[1][2];
    h[2][2] = longint'(item.h_zz);
    support = 1'b1;
    for (int i = 0; i < 3; i++) begin
      eta[i] = 0;
      for (int j = 0; j < 3; j++) eta[i] += round_shift(h[i][j] * sep[j], FRAC);
      if (eta[i] >= LIM31 || eta[i] <= -LIM31) support = 1'b0;
    end
    if (!support) return res;
    dist2 = 0;
    for (int i = 0; i < 3; i++) dist2 += longint'(eta[i] * eta[i]);
    ext2 = longint'(extent_q) * longint'(extent_q);
    if (dist2 > ext2) return res;
    res.in_support = 1'b1;
    // Inside the extent but past a scaled distance of two: weight and gradient are zero.
    if (dist2 > (64'd4 << (2 * FRAC))) return res;
    u = int_sqrt(dist2 << (60 - 2 * FRAC));
    if (dist2 <= (64'd1 << (2 * FRAC))) begin
      e2 = round_shift(longint'(u * u), 30);
      e3 = round_shift(e2 * longint'(u), 30);
      n4 = 4 * ONE30 - 6 * e2 + 3 * e3;
      d4 = -6 * ONE30 + 9 * e2;
      if (n4 < 0) n4 = 0;
      wt = round_shift(n4 * INV_PI_Q30, 32);
      dw = round_shift(d4 * INV_PI_Q30, 32);
    end else begin
      t = 2 * ONE30 - longint'(u);
      if (t < 0) t = 0;
      t2 = round_shift(t * t, 30);
      t3 = round_shift(t2 * t, 30);
      wt = round_shift(t3 * INV_PI_Q30, 32);
      dw = round_shift(-3 * t2 * INV_PI_Q30, 32);
    end
    if (wt < 0) wt = 0;
    if (wt > ONE30 - 1) wt = ONE30 - 1;
    res.weight = wt[sck_pkg::WEIGHT_W-1:0];
    // A zero scaled distance has no direction, so the gradient stays zero.
    if (u == 0) return res;
    for (int i = 0; i < 3; i++) begin
      wv[i] = (eta[i] * (64'sd1 <<< (30 - FRAC)) * dw) / longint'(u);
    end
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += h[i][j] * wv[j];
      acc = round_shift(acc, 30);
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      case (i)
        0: res.grad_x = acc[31:0];
        1: res.grad_y = acc[31:0];
        default: res.grad_z = acc[31:0];
      endcase
    end
    return res;
  endfunction

  // Predicts on input acceptance and checks each accepted result against the oldest
  // prediction. Both handshakes are sampled at the same edge the block uses.
  always @(posedge clk_i) begin
    sck_pkg::sck_out_t exp_res;
    if (rst_ni && in_valid_i && !in_stall_o) kernel_results_q.push_back(kernel_eval(in_data_i));
    if (rst_ni && cfg_valid_i && cfg_ready_o) extent_q <= cfg_data_i;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (kernel_results_q.size() == 0) begin
        $error("unexpected result: weight %0d", out_data_o.weight);
        error_count++;
      end else begin
        exp_res = kernel_results_q.pop_front();
        if (out_data_o.weight !== exp_res.weight) begin
          $error("weight: expected %0d, actual %0d", exp_res.weight, out_data_o.weight);
          error_count++;
        end
        if (out_data_o.grad_x !== exp_res.grad_x) begin
          $error("grad_x: expected %0d, actual %0d", exp_res.grad_x, out_data_o.grad_x);
          error_count++;
        end
        if (out_data_o.grad_y !== exp_res.grad_y) begin
          $error("grad_y: expected %0d, actual %0d", exp_res.grad_y, out_data_o.grad_y);
          error_count++;
        end
        if (out_data_o.grad_z !== exp_res.grad_z) begin
          $error("grad_z: expected %0d, actual %0d", exp_res.grad_z, out_data_o.grad_z);
          error_count++;
        end
        if (out_data_o.in_support !== exp_res.in_support) begin
          $error("in_support: expected %0d, actual %0d", exp_res.in_support,
                 out_data_o.in_support);
          error_count++;
        end
      end
    end
  end

  // The receiver stalls at random according to the current phase.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: a hung pipeline or handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offers one item, idling first at random, and returns once it has been accepted.
  // Valid stays high into the next call so back-to-back items see no bubble.
  task automatic send_item(input sck_pkg::sck_in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Waits until every predicted result has arrived and the pipeline has drained.
  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (kernel_results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes the extent register; only called with the block idle.
  task automatic write_extent(input logic [sck_pkg::EXTENT_W-1:0] value);
    drain_block();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
  endtask

  function automatic sck_pkg::sck_in_t make_item(input int sx, input int sy, input int sz,
                                                 input int hxx, input int hxy, input int hxz,
                                                 input int hyy, input int hyz, input int hzz);
    sck_pkg::sck_in_t item;
    item.sep_x = sx;
    item.sep_y = sy;
    item.sep_z = sz;
    item.h_xx = hxx;
    item.h_xy = hxy;
    item.h_xz = hxz;
    item.h_yy = hyy;
    item.h_yz = hyz;
    item.h_zz = hzz;
    return item;
  endfunction

  function automatic int rand_signed(input int unsigned span);
    return int'($urandom_range(2 * span)) - int'(span);
  endfunction

  // Mostly well-formed pairs near the support, some with a huge tensor and tiny
  // separation to drive gradient saturation, and some completely random noise.
  function automatic sck_pkg::sck_in_t random_item();
    int unsigned pick;
    int diag;
    pick = $urandom_range(99);
    if (pick < 70) begin
      diag = int'($urandom_range(32768, 131072));
      return make_item(rand_signed(1 << 17), rand_signed(1 << 17), rand_signed(1 << 17),
                       $urandom_range(1) ? diag : -diag, rand_signed(1 << 14),
                       rand_signed(1 << 14), rand_signed(1 << 17), rand_signed(1 << 14),
                       rand_signed(1 << 17));
    end else if (pick < 85) begin
      return make_item(rand_signed(4), rand_signed(4), rand_signed(4), $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom);
    end
    return make_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom);
  endfunction

  // Field extremes and the named corners at the reset extent of 2.0.
  task automatic test_directed();
    localparam int ONE = 65536;
    int min_v;
    int max_v;
    min_v = 32'sh80000000;
    max_v = 32'sh7fffffff;
    // Zero separation: weight is W(0) and the gradient is zero.
    send_item(make_item(0, 0, 0, ONE, 0, 0, ONE, 0, ONE));
    send_item(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Scaled distance of exactly one and exactly two, the region boundaries.
    send_item(make_item(ONE, 0, 0, ONE, 0, 0, ONE, 0, ONE));
    send_item(make_item(0, -2 * ONE, 0, ONE, 0, 0, ONE, 0, ONE));
    send_item(make_item(ONE / 2, ONE / 3, -ONE / 4, ONE, ONE / 8, -ONE / 8, ONE, 0, ONE));
    send_item(make_item(ONE, ONE, 0, ONE, 0, 0, ONE, 0, ONE));
    // Just past the extent.
    send_item(make_item(2 * ONE + 1, 0, 0, ONE, 0, 0, ONE, 0, ONE));
    // Huge eta components fall out of support; with every field at -1, eta rounds to zero.
    send_item(make_item(max_v, max_v, max_v, max_v, max_v, max_v, max_v, max_v, max_v));
    send_item(make_item(min_v, min_v, min_v, min_v, min_v, min_v, min_v, min_v, min_v));
    send_item(make_item(min_v, max_v, 0, max_v, min_v, 0, min_v, max_v, min_v));
    send_item(make_item(-1, -1, -1, -1, -1, -1, -1, -1, -1));
    // Huge tensor with tiny separation saturates the gradient both ways.
    send_item(make_item(1, 0, 0, max_v, 0, 0, max_v, 0, max_v));
    send_item(make_item(-1, 0, 0, max_v, max_v, max_v, max_v, max_v, max_v));
    send_item(make_item(1, 1, 1, min_v, min_v, min_v, min_v, min_v, min_v));
    send_item(make_item(0, 1, 0, min_v, max_v, min_v, max_v, min_v, max_v));
    drain_block();
  endtask

  // Extent corners: zero, one LSB, and the largest value with items beyond two.
  task automatic test_extent_extremes();
    localparam int ONE = 65536;
    write_extent('0);
    // With a zero extent only eta = 0 is in support.
    send_item(make_item(0, 0, 0, ONE, 0, 0, ONE, 0, ONE));
    send_item(make_item(1, 0, 0, ONE, 0, 0, ONE, 0, ONE));
    write_extent(31'd1);
    send_item(make_item(1, 0, 0, ONE, 0, 0, ONE, 0, ONE));
    send_item(make_item(1, 1, 0, ONE, 0, 0, ONE, 0, ONE));
    write_extent(EXTENT_MAX);
    // In support but beyond two gives a zero weight and gradient; the last item lies inside two.
    send_item(make_item(3 * ONE, 0, 0, ONE, 0, 0, ONE, 0, ONE));
    send_item(make_item(32'sh7fff0000, 0, 0, ONE, 0, 0, ONE, 0, ONE));
    send_item(make_item(ONE, ONE, ONE, ONE, 0, 0, ONE, 0, ONE));
    drain_block();
  endtask

  task automatic test_random_traffic(input int unsigned count, input int unsigned idle_pct,
                                     input int unsigned stall_pct,
                                     input logic [sck_pkg::EXTENT_W-1:0] extent_val);
    write_extent(extent_val);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_item(random_item());
    drain_block();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_extent_extremes();
    test_random_traffic(320, 38, 64, EXTENT_MAX);
    test_random_traffic(320, 64, 38, 31'($urandom_range(65536, 262144)));
    test_random_traffic(310, 0, 0, EXTENT_RESET);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/sck_pkg.sv
sv/sck_front.sv
sv/sck_queue.sv
sv/sck_back.sv
sv/sph_cubic_spline_kernel_eval.sv
sv/sck_checker.sv
tb/sv/sph_cubic_spline_kernel_eval_tb.sv
